/* rtl/kf2_pkg.sv */
`timescale 1ns / 1ps
// shared constants, register codes and saturation helper for the 2-state kalman step
package kf2_pkg;

    // fixed-point format and field widths
    localparam int FRAC_BITS  = 16;
    localparam int DATA_W     = 32;
    localparam int DT_W       = 17;
    localparam int NOISE_W    = 31;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 32;

    // reset values: 0.1 and 0.01 rounded to the fixed-point grid
    localparam logic [63:0] ONE_FX    = 64'd1 << FRAC_BITS;
    localparam logic [63:0] TENTH     = (ONE_FX + 64'd5) / 64'd10;
    localparam logic [63:0] HUNDREDTH = (ONE_FX + 64'd50) / 64'd100;

    localparam logic [DT_W-1:0]          DT_RESET    = TENTH[DT_W-1:0];
    localparam logic [NOISE_W-1:0]       NOISE_RESET = HUNDREDTH[NOISE_W-1:0];
    localparam logic signed [DATA_W-1:0] COV_RESET   = HUNDREDTH[DATA_W-1:0];

    // saturation bounds in the wide domain
    localparam logic signed [63:0] WIDE_MAX = 64'sh0000_0000_7FFF_FFFF;
    localparam logic signed [63:0] WIDE_MIN = 64'shFFFF_FFFF_8000_0000;

    // configuration register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_TIME_STEP  = CFG_IDX_W'(0),
        CFG_PROC_POS   = CFG_IDX_W'(1),
        CFG_PROC_VEL   = CFG_IDX_W'(2),
        CFG_MEAS_NOISE = CFG_IDX_W'(3)
    } cfg_reg_t;

    // clamp a wide signed value to the signed data range
    function automatic logic signed [DATA_W-1:0] sat32(input logic signed [63:0] v);
        logic signed [DATA_W-1:0] r;
        if (v > WIDE_MAX)
            r = WIDE_MAX[DATA_W-1:0];
        else if (v < WIDE_MIN)
            r = WIDE_MIN[DATA_W-1:0];
        else
            r = v[DATA_W-1:0];
        return r;
    endfunction

    // sign-extend a data word to the wide domain
    function automatic logic signed [63:0] wx(input logic signed [DATA_W-1:0] v);
        return {{(64-DATA_W){v[DATA_W-1]}}, v};
    endfunction

endpackage

/* rtl/kf2_ifs.sv */
`timescale 1ns / 1ps
// valid/ready channel interfaces for input items, results and configuration writes

interface kf2_in_if;
    logic                                valid;
    logic                                ready;
    logic signed [kf2_pkg::DATA_W-1:0]   accel_in;
    logic signed [kf2_pkg::DATA_W-1:0]   meas_pos;

    modport source (output valid, output accel_in, output meas_pos, input ready);
    modport sink   (input valid, input accel_in, input meas_pos, output ready);
endinterface

interface kf2_out_if;
    logic                                valid;
    logic                                ready;
    logic signed [kf2_pkg::DATA_W-1:0]   pos_est;
    logic signed [kf2_pkg::DATA_W-1:0]   vel_est;
    logic signed [kf2_pkg::DATA_W-1:0]   gain_pos;
    logic signed [kf2_pkg::DATA_W-1:0]   gain_vel;
    logic [kf2_pkg::NOISE_W-1:0]         var_pos;

    modport source (output valid, output pos_est, output vel_est, output gain_pos,
                    output gain_vel, output var_pos, input ready);
    modport sink   (input valid, input pos_est, input vel_est, input gain_pos,
                    input gain_vel, input var_pos, output ready);
endinterface

interface kf2_cfg_if;
    logic                                valid;
    logic                                ready;
    logic [kf2_pkg::CFG_IDX_W-1:0]       index;
    logic [kf2_pkg::CFG_DATA_W-1:0]      data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

/* rtl/kf2_div.sv */
`timescale 1ns / 1ps
// iterative restoring divider: saturated (num << FRAC_BITS) / den, truncated toward zero
module kf2_div (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                start,
    input  logic signed [kf2_pkg::DATA_W-1:0]   num,
    input  logic signed [kf2_pkg::DATA_W:0]     den,
    output logic                                done,
    output logic signed [kf2_pkg::DATA_W-1:0]   quo
);

    localparam int F     = kf2_pkg::FRAC_BITS;
    localparam int W     = kf2_pkg::DATA_W;
    localparam int CNT_W = $clog2(W);

    localparam logic [W-1:0] POS_MAX = {1'b0, {(W-1){1'b1}}};
    localparam logic [W-1:0] NEG_MIN = {1'b1, {(W-1){1'b0}}};

    typedef enum logic [2:0] {
        D_IDLE = 3'b001,
        D_RUN  = 3'b010,
        D_FIN  = 3'b100
    } dstate_t;

    dstate_t            dstate_reg, dstate_next;
    logic               done_reg, done_next;
    logic [CNT_W-1:0]   cnt_reg, cnt_next;

    logic [W-1:0]       rem_reg;
    logic [W-1:0]       quo_reg;
    logic [W-1:0]       den_reg;
    logic               neg_reg;
    logic [W-1:0]       q_reg;

    // operand magnitudes and early-out checks
    logic [W-1:0]       num_mag;
    logic [W-1:0]       den_mag;
    logic [W+F-1:0]     dividend;
    logic [F-1:0]       dvd_hi;
    logic               den_zero;
    logic               too_big;
    logic               neg_in;

    assign num_mag  = num[W-1] ? (~num[W-1:0] + W'(1)) : num[W-1:0];
    assign den_mag  = den[W] ? W'(~den + (W+1)'(1)) : den[W-1:0];
    assign dividend = {num_mag, {F{1'b0}}};
    assign dvd_hi   = dividend[W+F-1:W];
    assign den_zero = (den == '0);
    assign too_big  = ({{(W-F){1'b0}}, dvd_hi} >= den_mag);
    assign neg_in   = num[W-1] ^ den[W];

    // one quotient bit per cycle
    logic [W:0]         rem_sh;
    logic [W:0]         rem_diff;
    logic               q_bit;

    assign rem_sh   = {rem_reg, quo_reg[W-1]};
    assign rem_diff = rem_sh - {1'b0, den_reg};
    assign q_bit    = (rem_sh >= {1'b0, den_reg});

    // sign fix and clamp of the finished magnitude
    logic [W-1:0]       q_fixed;

    always_comb
    begin
        if (!neg_reg)
            q_fixed = quo_reg[W-1] ? POS_MAX : quo_reg;
        else
            q_fixed = (quo_reg > NEG_MIN) ? NEG_MIN : (~quo_reg + W'(1));
    end

    // sequencer
    always_comb
    begin
        dstate_next = dstate_reg;
        done_next   = 1'b0;
        cnt_next    = cnt_reg;
        unique case (dstate_reg)
            D_IDLE:
            begin
                if (start)
                begin
                    if (den_zero || too_big)
                        done_next = 1'b1;
                    else
                    begin
                        dstate_next = D_RUN;
                        cnt_next    = '0;
                    end
                end
            end
            D_RUN:
            begin
                cnt_next = cnt_reg + CNT_W'(1);
                if (cnt_reg == CNT_W'(W-1))
                    dstate_next = D_FIN;
            end
            D_FIN:
            begin
                done_next   = 1'b1;
                dstate_next = D_IDLE;
            end
            default:
            begin
                dstate_next = D_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            dstate_reg <= D_IDLE;
            done_reg   <= 1'b0;
            cnt_reg    <= '0;
        end
        else
        begin
            dstate_reg <= dstate_next;
            done_reg   <= done_next;
            cnt_reg    <= cnt_next;
        end
    end

    // datapath
    always_ff @(posedge clk)
    begin
        if (dstate_reg == D_IDLE && start)
        begin
            neg_reg <= neg_in;
            den_reg <= den_mag;
            rem_reg <= {{(W-F){1'b0}}, dvd_hi};
            quo_reg <= dividend[W-1:0];
            if (den_zero)
                q_reg <= '0;
            else if (too_big)
                q_reg <= neg_in ? NEG_MIN : POS_MAX;
        end
        else if (dstate_reg == D_RUN)
        begin
            rem_reg <= q_bit ? rem_diff[W-1:0] : rem_sh[W-1:0];
            quo_reg <= {quo_reg[W-2:0], q_bit};
        end
        else if (dstate_reg == D_FIN)
        begin
            q_reg <= q_fixed;
        end
    end

    assign done = done_reg;
    assign quo  = q_reg;

endmodule

/* rtl/kalman_filter_2state_step.sv */
`timescale 1ns / 1ps
// two-state constant-velocity kalman filter, one predict and correct per transaction
// each multiply runs through S_MUL and S_RND on the shared 32x32 multiplier (ten per item),
//   each gain on the bit-serial divider; a gain with a zero or saturating quotient needs no division
// one transaction at a time: the input is ready only while the sequencer is idle, and a
//   result still waiting on the output holds the sequencer
// reset: state and covariance go to 0 / 0.01, registers to dt 0.1 and noises 0.01
module kalman_filter_2state_step (
    input  logic            clk,
    input  logic            rst_n,
    kf2_cfg_if.sink         cfg,
    kf2_in_if.sink          in_item,
    kf2_out_if.source       out_item
);

    localparam int F = kf2_pkg::FRAC_BITS;
    localparam int W = kf2_pkg::DATA_W;

    localparam logic signed [63:0] RND_HALF = 64'sd1 <<< (F-1);

    // multiply steps of the sequence
    localparam logic [3:0] OP_DT_U   = 4'd0;
    localparam logic [3:0] OP_DT_V   = 4'd1;
    localparam logic [3:0] OP_DT_VV  = 4'd2;
    localparam logic [3:0] OP_DT_PV  = 4'd3;
    localparam logic [3:0] OP_DT_T   = 4'd4;
    localparam logic [3:0] OP_K0_Y   = 4'd5;
    localparam logic [3:0] OP_K1_Y   = 4'd6;
    localparam logic [3:0] OP_K0_PP  = 4'd7;
    localparam logic [3:0] OP_K0_PV  = 4'd8;
    localparam logic [3:0] OP_K1_PV  = 4'd9;

    typedef enum logic [8:0] {
        S_IDLE = 9'b000000001,
        S_MUL  = 9'b000000010,
        S_RND  = 9'b000000100,
        S_GAIN = 9'b000001000,
        S_DV0S = 9'b000010000,
        S_DV0W = 9'b000100000,
        S_DV1S = 9'b001000000,
        S_DV1W = 9'b010000000,
        S_PUSH = 9'b100000000
    } state_t;

    state_t                     state_reg, state_next;
    logic [3:0]                 step_reg, step_next;
    logic                       out_valid_reg, out_valid_next;

    // configuration registers
    logic [kf2_pkg::DT_W-1:0]       dt_reg;
    logic [kf2_pkg::NOISE_W-1:0]    qp_reg;
    logic [kf2_pkg::NOISE_W-1:0]    qv_reg;
    logic [kf2_pkg::NOISE_W-1:0]    r_reg;

    // filter state
    logic signed [W-1:0]        pos_reg, vel_reg, pp_reg, pv_reg, vv_reg;

    // per-item working registers
    logic signed [W-1:0]        u_reg, z_reg;
    logic signed [W-1:0]        vp_reg, posp_reg, pvp_reg, ppp_reg, vvp_reg;
    logic signed [W+1:0]        acc_reg;
    logic signed [W:0]          s_reg;
    logic signed [W-1:0]        y_reg, k0_reg, k1_reg;
    logic signed [63:0]         prod_reg;

    // result registers
    logic signed [W-1:0]        pos_out_reg, vel_out_reg, k0_out_reg, k1_out_reg;
    logic [kf2_pkg::NOISE_W-1:0] var_out_reg;

    // divider hookup
    logic                       div_start;
    logic signed [W-1:0]        div_num;
    logic                       div_done;
    logic signed [W-1:0]        div_quo;

    logic in_fire, out_fire, cfg_fire;

    assign in_item.ready = (state_reg == S_IDLE);
    assign cfg.ready     = 1'b1;
    assign in_fire       = in_item.valid && in_item.ready;
    assign out_fire      = out_valid_reg && out_item.ready;
    assign cfg_fire      = cfg.valid && cfg.ready;

    // operand select for the shared multiplier
    logic signed [W-1:0] mul_a, mul_b;
    logic signed [W-1:0] dt_word;

    assign dt_word = {{(W-kf2_pkg::DT_W){1'b0}}, dt_reg};

    always_comb
    begin
        unique case (step_reg)
            OP_DT_U:  begin mul_a = dt_word; mul_b = u_reg;   end
            OP_DT_V:  begin mul_a = dt_word; mul_b = vel_reg; end
            OP_DT_VV: begin mul_a = dt_word; mul_b = vv_reg;  end
            OP_DT_PV: begin mul_a = dt_word; mul_b = pv_reg;  end
            OP_DT_T:  begin mul_a = dt_word; mul_b = pvp_reg; end
            OP_K0_Y:  begin mul_a = k0_reg;  mul_b = y_reg;   end
            OP_K1_Y:  begin mul_a = k1_reg;  mul_b = y_reg;   end
            OP_K0_PP: begin mul_a = k0_reg;  mul_b = ppp_reg; end
            OP_K0_PV: begin mul_a = k0_reg;  mul_b = pvp_reg; end
            OP_K1_PV: begin mul_a = k1_reg;  mul_b = pvp_reg; end
            default:  begin mul_a = '0;      mul_b = '0;      end
        endcase
    end

    // round half up, floor shift, clamp
    logic signed [63:0] rnd_sum, rnd_shift;
    logic signed [W-1:0] term;

    assign rnd_sum   = prod_reg + RND_HALF;
    assign rnd_shift = rnd_sum >>> F;
    assign term      = kf2_pkg::sat32(rnd_shift);

    // exact sums of the predict step
    logic signed [63:0] acc_wide, qp_wide, qv_wide, r_wide;

    assign acc_wide = {{(64-W-2){acc_reg[W+1]}}, acc_reg};
    assign qp_wide  = {{(64-kf2_pkg::NOISE_W){1'b0}}, qp_reg};
    assign qv_wide  = {{(64-kf2_pkg::NOISE_W){1'b0}}, qv_reg};
    assign r_wide   = {{(64-kf2_pkg::NOISE_W){1'b0}}, r_reg};

    logic signed [63:0] acc_sum, s_sum;

    assign acc_sum = kf2_pkg::wx(pp_reg) + kf2_pkg::wx(term);
    assign s_sum   = kf2_pkg::wx(ppp_reg) + r_wide;

    // sequencer
    always_comb
    begin
        state_next     = state_reg;
        step_next      = step_reg;
        out_valid_next = out_valid_reg;
        if (out_fire)
            out_valid_next = 1'b0;
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_fire)
                begin
                    state_next = S_MUL;
                    step_next  = OP_DT_U;
                end
            end
            S_MUL:
            begin
                state_next = S_RND;
            end
            S_RND:
            begin
                if (step_reg == OP_DT_T)
                    state_next = S_GAIN;
                else if (step_reg == OP_K1_PV)
                    state_next = S_PUSH;
                else
                begin
                    state_next = S_MUL;
                    step_next  = step_reg + 4'd1;
                end
            end
            S_GAIN:
            begin
                state_next = S_DV0S;
            end
            S_DV0S:
            begin
                state_next = S_DV0W;
            end
            S_DV0W:
            begin
                if (div_done)
                    state_next = S_DV1S;
            end
            S_DV1S:
            begin
                state_next = S_DV1W;
            end
            S_DV1W:
            begin
                if (div_done)
                begin
                    state_next = S_MUL;
                    step_next  = OP_K0_Y;
                end
            end
            S_PUSH:
            begin
                if (!out_valid_reg || out_item.ready)
                begin
                    out_valid_next = 1'b1;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            step_reg      <= OP_DT_U;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            step_reg      <= step_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            dt_reg <= kf2_pkg::DT_RESET;
            qp_reg <= kf2_pkg::NOISE_RESET;
            qv_reg <= kf2_pkg::NOISE_RESET;
            r_reg  <= kf2_pkg::NOISE_RESET;
        end
        else if (cfg_fire)
        begin
            unique case (kf2_pkg::cfg_reg_t'(cfg.index))
                kf2_pkg::CFG_TIME_STEP:  dt_reg <= cfg.data[kf2_pkg::DT_W-1:0];
                kf2_pkg::CFG_PROC_POS:   qp_reg <= cfg.data[kf2_pkg::NOISE_W-1:0];
                kf2_pkg::CFG_PROC_VEL:   qv_reg <= cfg.data[kf2_pkg::NOISE_W-1:0];
                kf2_pkg::CFG_MEAS_NOISE: r_reg  <= cfg.data[kf2_pkg::NOISE_W-1:0];
                default:                 dt_reg <= dt_reg;
            endcase
        end
    end

    // filter state, updated by the correct step
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg <= '0;
            vel_reg <= '0;
            pp_reg  <= kf2_pkg::COV_RESET;
            pv_reg  <= '0;
            vv_reg  <= kf2_pkg::COV_RESET;
        end
        else if (state_reg == S_RND)
        begin
            unique case (step_reg)
                OP_K0_Y:  pos_reg <= kf2_pkg::sat32(kf2_pkg::wx(posp_reg) + kf2_pkg::wx(term));
                OP_K1_Y:  vel_reg <= kf2_pkg::sat32(kf2_pkg::wx(vp_reg) + kf2_pkg::wx(term));
                OP_K0_PP: pp_reg  <= kf2_pkg::sat32(kf2_pkg::wx(ppp_reg) - kf2_pkg::wx(term));
                OP_K0_PV: pv_reg  <= kf2_pkg::sat32(kf2_pkg::wx(pvp_reg) - kf2_pkg::wx(term));
                OP_K1_PV: vv_reg  <= kf2_pkg::sat32(kf2_pkg::wx(vvp_reg) - kf2_pkg::wx(term));
                default:  pos_reg <= pos_reg;
            endcase
        end
    end

    // working registers of one item
    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            u_reg <= in_item.accel_in;
            z_reg <= in_item.meas_pos;
        end

        if (state_reg == S_MUL)
            prod_reg <= mul_a * mul_b;

        if (state_reg == S_RND)
        begin
            unique case (step_reg)
                OP_DT_U:  vp_reg   <= kf2_pkg::sat32(kf2_pkg::wx(vel_reg) + kf2_pkg::wx(term));
                OP_DT_V:  posp_reg <= kf2_pkg::sat32(kf2_pkg::wx(pos_reg) + kf2_pkg::wx(term));
                OP_DT_VV: pvp_reg  <= kf2_pkg::sat32(kf2_pkg::wx(pv_reg) + kf2_pkg::wx(term));
                OP_DT_PV: acc_reg  <= acc_sum[W+1:0];
                OP_DT_T:
                begin
                    ppp_reg <= kf2_pkg::sat32(acc_wide + kf2_pkg::wx(term) + qp_wide);
                    vvp_reg <= kf2_pkg::sat32(kf2_pkg::wx(vv_reg) + qv_wide);
                end
                default:  prod_reg <= prod_reg;
            endcase
        end

        // innovation variance and innovation
        if (state_reg == S_GAIN)
        begin
            s_reg <= s_sum[W:0];
            y_reg <= kf2_pkg::sat32(kf2_pkg::wx(z_reg) - kf2_pkg::wx(posp_reg));
        end

        if (state_reg == S_DV0W && div_done)
            k0_reg <= div_quo;
        if (state_reg == S_DV1W && div_done)
            k1_reg <= div_quo;

        // result load
        if (state_reg == S_PUSH && (!out_valid_reg || out_item.ready))
        begin
            pos_out_reg <= pos_reg;
            vel_out_reg <= vel_reg;
            k0_out_reg  <= k0_reg;
            k1_out_reg  <= k1_reg;
            var_out_reg <= pp_reg[W-1] ? '0 : pp_reg[kf2_pkg::NOISE_W-1:0];
        end
    end

    // shared divider for both gains
    assign div_start = (state_reg == S_DV0S) || (state_reg == S_DV1S);
    assign div_num   = (state_reg == S_DV1S) ? pvp_reg : ppp_reg;

    kf2_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .start (div_start),
        .num   (div_num),
        .den   (s_reg),
        .done  (div_done),
        .quo   (div_quo)
    );

    // result channel
    assign out_item.valid    = out_valid_reg;
    assign out_item.pos_est  = pos_out_reg;
    assign out_item.vel_est  = vel_out_reg;
    assign out_item.gain_pos = k0_out_reg;
    assign out_item.gain_vel = k1_out_reg;
    assign out_item.var_pos  = var_out_reg;

endmodule

/* tb/kf2_estimate_checker.sv */
`timescale 1ns / 1ps
// estimate checker: predicts every kalman step from the observed transactions and compares results
module kf2_estimate_checker
    import kf2_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    kf2_cfg_if   cfg_mon,
    kf2_in_if    in_mon,
    kf2_out_if   out_mon,
    output int   fail_count,
    output int   pending
);

    localparam longint S32_MAX = 64'sd2147483647;
    localparam longint S32_MIN = -64'sd2147483648;
    localparam longint UNIT    = 64'sd1 <<< FRAC_BITS;
    localparam longint HALF    = 64'sd1 <<< (FRAC_BITS - 1);

    typedef struct packed {
        logic [DATA_W-1:0]  pos;
        logic [DATA_W-1:0]  vel;
        logic [DATA_W-1:0]  gain_p;
        logic [DATA_W-1:0]  gain_v;
        logic [NOISE_W-1:0] var_p;
    } estimate_t;

    // register shadows
    longint dt_r;
    longint qpos_r;
    longint qvel_r;
    longint rmeas_r;

    // filter state shadows
    longint pos_q;
    longint vel_q;
    longint pp_q;
    longint pv_q;
    longint vv_q;

    estimate_t estimates_due[$];
    estimate_t oldest;

    // clamp to the signed 32-bit range
    function automatic longint clamp32(longint v);
        if (v > S32_MAX)
            return S32_MAX;
        if (v < S32_MIN)
            return S32_MIN;
        return v;
    endfunction

    // fixed-point product, rounded half up by a floored shift
    function automatic longint fx_product(longint a, longint b);
        return clamp32((a * b + HALF) >>> FRAC_BITS);
    endfunction

    // fixed-point quotient, truncated toward zero, zero for a zero divisor
    function automatic longint fx_quot(longint num, longint den);
        if (den == 0)
            return 0;
        return clamp32((num * UNIT) / den);
    endfunction

    // one predict and correct pass on the shadow state
    function automatic estimate_t predict_estimate(longint u, longint z);
        longint    vel_p;
        longint    pos_p;
        longint    pv_p;
        longint    pp_p;
        longint    vv_p;
        longint    s;
        longint    k_p;
        longint    k_v;
        longint    innov;
        estimate_t e;

        // predict
        vel_p = clamp32(vel_q + fx_product(dt_r, u));
        pos_p = clamp32(pos_q + fx_product(dt_r, vel_q));
        pv_p  = clamp32(pv_q + fx_product(dt_r, vv_q));
        pp_p  = clamp32(pp_q + fx_product(dt_r, pv_q) + fx_product(dt_r, pv_p) + qpos_r);
        vv_p  = clamp32(vv_q + qvel_r);

        // gain
        s   = pp_p + rmeas_r;
        k_p = fx_quot(pp_p, s);
        k_v = fx_quot(pv_p, s);

        // correct
        innov = clamp32(z - pos_p);
        pos_q = clamp32(pos_p + fx_product(k_p, innov));
        vel_q = clamp32(vel_p + fx_product(k_v, innov));
        pp_q  = clamp32(pp_p - fx_product(k_p, pp_p));
        pv_q  = clamp32(pv_p - fx_product(k_p, pv_p));
        vv_q  = clamp32(vv_p - fx_product(k_v, pv_p));

        e.pos    = pos_q[DATA_W-1:0];
        e.vel    = vel_q[DATA_W-1:0];
        e.gain_p = k_p[DATA_W-1:0];
        e.gain_v = k_v[DATA_W-1:0];
        // a negative variance reads as zero
        e.var_p  = (pp_q < 0) ? '0 : pp_q[NOISE_W-1:0];
        return e;
    endfunction

    task automatic flag_mismatch(string what);
        $display("[%0t] mismatch: %s", $time, what);
        fail_count = fail_count + 1;
    endtask

    task automatic check_field(string field, logic [DATA_W-1:0] got, logic [DATA_W-1:0] want);
        if (got !== want)
            flag_mismatch($sformatf("%s got %h want %h", field, got, want));
    endtask

    // watch the three channels
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            dt_r       = longint'(DT_RESET);
            qpos_r     = longint'(NOISE_RESET);
            qvel_r     = longint'(NOISE_RESET);
            rmeas_r    = longint'(NOISE_RESET);
            pos_q      = 0;
            vel_q      = 0;
            pp_q       = longint'(COV_RESET);
            pv_q       = 0;
            vv_q       = longint'(COV_RESET);
            fail_count = 0;
            estimates_due.delete();
            pending    <= 0;
        end
        else
        begin
            // register write transaction
            if (cfg_mon.valid && cfg_mon.ready)
            begin
                case (cfg_reg_t'(cfg_mon.index))
                    CFG_TIME_STEP:  dt_r    = longint'(cfg_mon.data[DT_W-1:0]);
                    CFG_PROC_POS:   qpos_r  = longint'(cfg_mon.data[NOISE_W-1:0]);
                    CFG_PROC_VEL:   qvel_r  = longint'(cfg_mon.data[NOISE_W-1:0]);
                    CFG_MEAS_NOISE: rmeas_r = longint'(cfg_mon.data[NOISE_W-1:0]);
                    default: ;
                endcase
            end

            // input transaction
            if (in_mon.valid && in_mon.ready)
                estimates_due.push_back(predict_estimate(in_mon.accel_in, in_mon.meas_pos));

            // result transaction
            if (out_mon.valid && out_mon.ready)
            begin
                if (estimates_due.size() == 0)
                begin
                    flag_mismatch("result with no estimate outstanding");
                end
                else
                begin
                    oldest = estimates_due.pop_front();
                    check_field("pos_est", out_mon.pos_est, oldest.pos);
                    check_field("vel_est", out_mon.vel_est, oldest.vel);
                    check_field("gain_pos", out_mon.gain_pos, oldest.gain_p);
                    check_field("gain_vel", out_mon.gain_vel, oldest.gain_v);
                    check_field("var_pos", DATA_W'(out_mon.var_pos), DATA_W'(oldest.var_p));
                end
            end

            pending <= estimates_due.size();
        end
    end

endmodule

/* tb/tb_top.sv */
`timescale 1ns / 1ps
// bench top: clock, reset, stimulus, output stalls and the final verdict for the kalman step
module tb_top;
    import kf2_pkg::*;

    localparam int     CYCLE_LIMIT   = 1_000_000;
    localparam int     SETTLE_CYCLES = 100;
    localparam int     RANDOM_PHASES = 8;
    localparam int     PHASE_ITEMS   = 230;
    localparam int     ACCEL_SPAN    = 4 << FRAC_BITS;
    localparam longint MEAS_SPREAD   = 64'sd1 <<< FRAC_BITS;
    localparam longint TRACK_LIM     = 64'sd1 <<< 28;

    logic        clk = 1'b0;
    logic        rst_n;
    int          fail_count;
    int          pending;
    int unsigned cycles = 0;
    longint      track_pos = 0;
    longint      track_vel = 0;

    kf2_cfg_if cfg_ch ();
    kf2_in_if  in_ch ();
    kf2_out_if out_ch ();

    kalman_filter_2state_step u_top (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg      (cfg_ch),
        .in_item  (in_ch),
        .out_item (out_ch)
    );

    kf2_estimate_checker u_checker (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_mon    (cfg_ch),
        .in_mon     (in_ch),
        .out_mon    (out_ch),
        .fail_count (fail_count),
        .pending    (pending)
    );

    // 2 ns clock
    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    // hard stop on a hung run
    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT)
        begin
            $display("TB_ERROR");
            $finish;
        end
    end

    // output stalls: always ready, random, or a rotating bit mask
    initial
    begin
        int         mode;
        int         span;
        int         slot;
        logic [7:0] mask;
        out_ch.ready <= 1'b0;
        slot = 0;
        forever
        begin
            mode = $urandom_range(0, 2);
            span = $urandom_range(32, 400);
            mask = 8'($urandom_range(1, 255));
            repeat (span)
            begin
                @(posedge clk);
                case (mode)
                    0:       out_ch.ready <= 1'b1;
                    1:       out_ch.ready <= ($urandom_range(0, 3) != 0);
                    default: out_ch.ready <= mask[slot];
                endcase
                slot = (slot + 1) % 8;
            end
        end
    end

    // hold one register write until accepted; valid stays high for the next one
    task automatic write_reg(cfg_reg_t idx, logic [CFG_DATA_W-1:0] value);
        cfg_ch.valid <= 1'b1;
        cfg_ch.index <= idx;
        cfg_ch.data  <= value;
        do
            @(posedge clk);
        while (!cfg_ch.ready);
    endtask

    task automatic set_config(logic [CFG_DATA_W-1:0] dt, logic [CFG_DATA_W-1:0] qp,
                              logic [CFG_DATA_W-1:0] qv, logic [CFG_DATA_W-1:0] r);
        write_reg(CFG_TIME_STEP, dt);
        write_reg(CFG_PROC_POS, qp);
        write_reg(CFG_PROC_VEL, qv);
        write_reg(CFG_MEAS_NOISE, r);
        cfg_ch.valid <= 1'b0;
    endtask

    // hold one input transaction until accepted
    task automatic send_item(logic [DATA_W-1:0] a, logic [DATA_W-1:0] z);
        in_ch.valid    <= 1'b1;
        in_ch.accel_in <= a;
        in_ch.meas_pos <= z;
        do
            @(posedge clk);
        while (!in_ch.ready);
    endtask

    // wait until every estimate has come back, then let the block settle
    task automatic drain();
        do
            @(posedge clk);
        while (pending != 0);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    function automatic logic [DATA_W-1:0] corner_word();
        case ($urandom_range(0, 5))
            0:       return 32'h8000_0000;
            1:       return 32'h7FFF_FFFF;
            2:       return 32'h0000_0000;
            3:       return 32'hFFFF_FFFF;
            4:       return 32'h0000_0001;
            default: return 32'h0001_0000;
        endcase
    endfunction

    // register value: zero, field max, raw word (upper bits too) or a plausible size
    function automatic logic [CFG_DATA_W-1:0] pick_reg(bit is_dt);
        case ($urandom_range(0, 5))
            0:       return '0;
            1:       return is_dt ? 32'h0001_FFFF : 32'h7FFF_FFFF;
            2:       return $urandom;
            default: return is_dt ? $urandom_range(0, 65536) : $urandom_range(0, 1 << 20);
        endcase
    endfunction

    // mostly a plausible track with noisy measurements, some raw words and corners
    task automatic pick_item(output logic [DATA_W-1:0] a, output logic [DATA_W-1:0] z);
        int sel;
        sel = $urandom_range(0, 99);
        if (sel < 70)
        begin
            a = $urandom_range(0, 2 * ACCEL_SPAN) - ACCEL_SPAN;
            track_vel = track_vel + ($signed(a) >>> 4);
            if (track_vel > TRACK_LIM)
                track_vel = TRACK_LIM;
            else if (track_vel < -TRACK_LIM)
                track_vel = -TRACK_LIM;
            track_pos = track_pos + (track_vel >>> 4);
            if (track_pos > TRACK_LIM)
                track_pos = TRACK_LIM;
            else if (track_pos < -TRACK_LIM)
                track_pos = -TRACK_LIM;
            z = 32'(track_pos + longint'($urandom_range(0, 2 * MEAS_SPREAD)) - MEAS_SPREAD);
        end
        else if (sel < 90)
        begin
            a = $urandom;
            z = $urandom;
        end
        else
        begin
            a = corner_word();
            z = corner_word();
        end
    endtask

    // bursts of transactions with random gaps, now and then a full drain
    task automatic run_items(int count);
        int                left;
        int                burst;
        int                gap;
        logic [DATA_W-1:0] a;
        logic [DATA_W-1:0] z;
        left = count;
        while (left > 0)
        begin
            burst = $urandom_range(1, 16);
            if (burst > left)
                burst = left;
            repeat (burst)
            begin
                pick_item(a, z);
                send_item(a, z);
            end
            left = left - burst;
            if (left == 0)
            begin
                in_ch.valid <= 1'b0;
            end
            else if ($urandom_range(0, 49) == 0)
            begin
                in_ch.valid <= 1'b0;
                drain();
            end
            else
            begin
                gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
                if (gap > 0)
                begin
                    in_ch.valid <= 1'b0;
                    repeat (gap) @(posedge clk);
                end
            end
        end
    endtask

    // stimulus and verdict
    initial
    begin
        rst_n          <= 1'b0;
        cfg_ch.valid   <= 1'b0;
        cfg_ch.index   <= CFG_TIME_STEP;
        cfg_ch.data    <= '0;
        in_ch.valid    <= 1'b0;
        in_ch.accel_in <= '0;
        in_ch.meas_pos <= '0;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // field corners at the reset settings
        send_item(32'h0000_0000, 32'h0000_0000);
        send_item(32'h7FFF_FFFF, 32'h7FFF_FFFF);
        send_item(32'h8000_0000, 32'h8000_0000);
        send_item(32'h7FFF_FFFF, 32'h8000_0000);
        send_item(32'h8000_0000, 32'h7FFF_FFFF);
        send_item(32'h0001_0000, 32'hFFFF_0000);
        in_ch.valid <= 1'b0;
        drain();

        // no noise, dt 0: first step drives pp to zero, then s is zero and gains vanish
        set_config(32'h0, 32'h0, 32'h0, 32'h0);
        send_item(32'h0001_0000, 32'h0002_0000);
        send_item(32'h0000_0000, 32'h0003_0000);
        send_item(32'hFFFF_FFFF, 32'h8000_0000);
        in_ch.valid <= 1'b0;
        drain();

        // everything at its field max: covariance saturates
        set_config(32'h0001_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
        send_item(32'h7FFF_FFFF, 32'h8000_0000);
        send_item(32'h8000_0000, 32'h7FFF_FFFF);
        send_item(32'h0000_0000, 32'h0000_0000);
        send_item(32'h7FFF_FFFF, 32'h7FFF_FFFF);
        in_ch.valid <= 1'b0;
        drain();

        // large dt without velocity or measurement noise pushes variances negative
        set_config(32'h0001_FFFF, 32'h7FFF_FFFF, 32'h0, 32'h0);
        send_item(32'h8000_0000, 32'h8000_0000);
        send_item(32'h7FFF_FFFF, 32'h0000_0001);
        send_item(32'h0000_0001, 32'h7FFF_FFFF);
        send_item(32'hFFFF_FFFF, 32'h0000_0000);
        in_ch.valid <= 1'b0;
        drain();

        // only bits above each field: writes mask down to zero
        set_config(32'hFFFE_0000, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000);
        send_item(32'h0001_0000, 32'h0001_0000);
        send_item(32'h8000_0000, 32'h7FFF_FFFF);
        send_item(32'h0000_0000, 32'hFFFF_FFFF);
        in_ch.valid <= 1'b0;
        drain();

        // random phases, first one back at the reset settings
        for (int p = 0; p < RANDOM_PHASES; p++)
        begin
            if (p == 0)
                set_config(DT_RESET, NOISE_RESET, NOISE_RESET, NOISE_RESET);
            else
                set_config(pick_reg(1'b1), pick_reg(1'b0), pick_reg(1'b0), pick_reg(1'b0));
            run_items(PHASE_ITEMS);
            drain();
        end

        @(negedge clk);
        if (fail_count == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule

/* kalman_filter_2state_step.f */
rtl/kf2_pkg.sv
rtl/kf2_ifs.sv
rtl/kf2_div.sv
rtl/kalman_filter_2state_step.sv
tb/kf2_estimate_checker.sv
tb/tb_top.sv
